// ===== hdl/ihb_pkg.sv =====
`timescale 1ns / 1ps

package ihb_pkg;

	localparam int HDR_BYTES = 34;
	localparam logic [5:0] LAST_IDX = 6'(HDR_BYTES - 1);

	localparam logic [7:0] CFG_OWN_MAC = 8'd0;
	localparam logic [7:0] CFG_OWN_IP  = 8'd1;

	localparam logic [7:0] ETH_TYPE_HI  = 8'h08;
	localparam logic [7:0] ETH_TYPE_LO  = 8'h00;
	localparam logic [7:0] IP_VER_IHL   = 8'h45;
	localparam logic [7:0] IP_TOS       = 8'h00;
	localparam logic [7:0] IP_FLAGS_DF  = 8'h40;
	localparam logic [7:0] IP_FRAG_LO   = 8'h00;
	localparam logic [7:0] IP_TTL       = 8'h80;
	localparam logic [15:0] IP_LEN_BIAS = 16'd20;

	typedef struct packed {
		logic [47:0] own_mac;
		logic [31:0] own_ip;
	} cfg_regs_t;

	typedef struct packed {
		logic [47:0] dmac;
		logic [31:0] dest_ip;
		logic [7:0]  proto;
		logic [15:0] total;
		logic [15:0] ident;
		logic [15:0] csum;
	} hdr_req_t;

endpackage

// ===== hdl/ihb_front.sv =====
`timescale 1ns / 1ps

module ihb_front import ihb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [47:0] dest_mac_addr,
	input  logic [31:0] dest_ip_addr,
	input  logic [7:0]  protocol,
	input  logic [15:0] payload_length,
	input  cfg_regs_t   cfg,
	input  logic        q_full,
	output logic        q_push,
	output hdr_req_t    q_data
);

	logic        adv;
	logic        v_s1, v_s2, v_s3;
	logic [15:0] ident_q;
	hdr_req_t    req_s1, req_s2, req_s3;
	logic [17:0] sum_a_s2, sum_b_s2;
	logic [18:0] sum_s3;
	logic [16:0] fold1;
	logic [15:0] fold2;

	assign adv    = !(v_s3 && q_full);
	assign full   = !adv;
	assign q_push = v_s3 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			ident_q <= '0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (push) begin
				ident_q <= ident_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1.dmac    <= dest_mac_addr;
			req_s1.dest_ip <= dest_ip_addr;
			req_s1.proto   <= protocol;
			req_s1.total   <= payload_length + IP_LEN_BIAS;
			req_s1.ident   <= ident_q;
			req_s1.csum    <= '0;

			// header words split in two partial sums; checksum field counts as zero
			req_s2   <= req_s1;
			sum_a_s2 <= 18'({IP_VER_IHL, IP_TOS}) + 18'(req_s1.total)
				+ 18'(req_s1.ident) + 18'({IP_FLAGS_DF, IP_FRAG_LO})
				+ 18'({IP_TTL, req_s1.proto});
			sum_b_s2 <= 18'(cfg.own_ip[31:16]) + 18'(cfg.own_ip[15:0])
				+ 18'(req_s1.dest_ip[31:16]) + 18'(req_s1.dest_ip[15:0]);

			req_s3 <= req_s2;
			sum_s3 <= 19'(sum_a_s2) + 19'(sum_b_s2);
		end
	end

	// end-around carry, two folds are enough for a 19-bit sum
	assign fold1 = 17'(sum_s3[15:0]) + 17'(sum_s3[18:16]);
	assign fold2 = fold1[15:0] + 16'(fold1[16]);

	always_comb begin
		q_data      = req_s3;
		q_data.csum = ~fold2;
	end

endmodule

// ===== hdl/ihb_fifo.sv =====
`timescale 1ns / 1ps

module ihb_fifo import ihb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  hdr_req_t wr_data,
	input  logic     rd_en,
	output hdr_req_t rd_data,
	output logic     full,
	output logic     empty
);

	hdr_req_t   mem [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr, do_rd;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data = mem[rd_ptr_q];

endmodule

// ===== hdl/ihb_back.sv =====
`timescale 1ns / 1ps

module ihb_back import ihb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_regs_t   cfg,
	input  hdr_req_t    req,
	input  logic        q_empty,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  header_byte,
	output logic [5:0]  byte_index,
	output logic        last
);

	logic [5:0] cnt_q;
	logic       take;

	assign empty       = q_empty;
	assign take        = pop && !q_empty;
	assign byte_index  = cnt_q;
	assign last        = (cnt_q == LAST_IDX);
	assign q_pop       = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= last ? 6'd0 : cnt_q + 6'd1;
		end
	end

	always_comb begin
		unique case (cnt_q)
			6'd0:    header_byte = req.dmac[47:40];
			6'd1:    header_byte = req.dmac[39:32];
			6'd2:    header_byte = req.dmac[31:24];
			6'd3:    header_byte = req.dmac[23:16];
			6'd4:    header_byte = req.dmac[15:8];
			6'd5:    header_byte = req.dmac[7:0];
			6'd6:    header_byte = cfg.own_mac[47:40];
			6'd7:    header_byte = cfg.own_mac[39:32];
			6'd8:    header_byte = cfg.own_mac[31:24];
			6'd9:    header_byte = cfg.own_mac[23:16];
			6'd10:   header_byte = cfg.own_mac[15:8];
			6'd11:   header_byte = cfg.own_mac[7:0];
			6'd12:   header_byte = ETH_TYPE_HI;
			6'd13:   header_byte = ETH_TYPE_LO;
			6'd14:   header_byte = IP_VER_IHL;
			6'd15:   header_byte = IP_TOS;
			6'd16:   header_byte = req.total[15:8];
			6'd17:   header_byte = req.total[7:0];
			6'd18:   header_byte = req.ident[15:8];
			6'd19:   header_byte = req.ident[7:0];
			6'd20:   header_byte = IP_FLAGS_DF;
			6'd21:   header_byte = IP_FRAG_LO;
			6'd22:   header_byte = IP_TTL;
			6'd23:   header_byte = req.proto;
			6'd24:   header_byte = req.csum[15:8];
			6'd25:   header_byte = req.csum[7:0];
			6'd26:   header_byte = cfg.own_ip[31:24];
			6'd27:   header_byte = cfg.own_ip[23:16];
			6'd28:   header_byte = cfg.own_ip[15:8];
			6'd29:   header_byte = cfg.own_ip[7:0];
			6'd30:   header_byte = req.dest_ip[31:24];
			6'd31:   header_byte = req.dest_ip[23:16];
			6'd32:   header_byte = req.dest_ip[15:8];
			6'd33:   header_byte = req.dest_ip[7:0];
			default: header_byte = '0;
		endcase
	end

endmodule

// ===== hdl/ipv4_eth_header_builder_unit.sv =====
// Ethernet + IPv4 header builder. Each request pushed in (destination MAC, destination
// IP, protocol, payload length) comes out as 34 header bytes, one word per pop, with
// byte_index 0..33 and last on byte 33. The IPv4 identification starts at 0 after
// reset and steps by one per request. A request passes the checksum pipeline stages
// (held while a finished request waits on a full queue) before it lands in a two-entry
// queue; the first byte can be popped the cycle after it is written there. The byte-wide
// result side limits throughput, with new requests taken while bytes stream out. The user
// must write own_mac and own_ip through cfg_we/cfg_index/cfg_wdata only when no request
// is in flight; the block does not enforce this. Other indexes are ignored.
`timescale 1ns / 1ps

module ipv4_eth_header_builder_unit import ihb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_index,
	input  logic [47:0] cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [47:0] dest_mac_addr,
	input  logic [31:0] dest_ip_addr,
	input  logic [7:0]  protocol,
	input  logic [15:0] payload_length,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  header_byte,
	output logic [5:0]  byte_index,
	output logic        last
);

	cfg_regs_t cfg_q;
	logic      q_push, q_pop, q_full, q_empty;
	hdr_req_t  q_wr_data, q_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OWN_MAC: cfg_q.own_mac <= cfg_wdata;
				CFG_OWN_IP:  cfg_q.own_ip  <= cfg_wdata[31:0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	ihb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.dest_mac_addr  (dest_mac_addr),
		.dest_ip_addr   (dest_ip_addr),
		.protocol       (protocol),
		.payload_length (payload_length),
		.cfg            (cfg_q),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (q_wr_data)
	);

	ihb_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	ihb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.req         (q_rd_data),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.header_byte (header_byte),
		.byte_index  (byte_index),
		.last        (last)
	);

	// bytes of one header go out in order with no gaps in the index
	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last) |=> (byte_index == $past(byte_index) + 6'd1))
		else $error("byte index skipped");

	// a new header always starts at byte zero
	a_index_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && last) |=> (byte_index == 6'd0))
		else $error("header did not restart at byte zero");

	// a waiting word is never dropped before it is taken
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && byte_index == $past(byte_index)))
		else $error("waiting word lost");

	// the front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue overflow");

endmodule

// ===== test/tb_ipv4_eth_header_builder_unit.sv =====
`timescale 1ns / 1ps

module tb_ipv4_eth_header_builder_unit;
	import ihb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [7:0] CFG_UNUSED_LO = 8'd2;
	localparam logic [7:0] CFG_UNUSED_HI = 8'hFF;

	typedef struct {
		logic [7:0] hbyte;
		logic [5:0] idx;
		logic       lst;
	} hdr_word_t;

	class hdr_scoreboard;
		logic [47:0] own_mac;
		logic [31:0] own_ip;
		logic [15:0] ident;
		hdr_word_t   hdr_words[$];
		int          errors;

		function new();
			own_mac = '0;
			own_ip  = '0;
			ident   = '0;
			errors  = 0;
		endfunction

		function void write_reg(logic [7:0] idx, logic [47:0] val);
			if (idx == CFG_OWN_MAC) begin
				own_mac = val;
			end else if (idx == CFG_OWN_IP) begin
				own_ip = val[31:0];
			end
		endfunction

		// folded ones'-complement sum of the ip header, checksum field as zero
		function logic [15:0] ones_sum(logic [31:0] dip, logic [7:0] proto, logic [15:0] plen);
			logic [31:0] sum;
			logic [15:0] total;
			total = plen + IP_LEN_BIAS;
			sum = {IP_VER_IHL, IP_TOS} + total + ident + {IP_FLAGS_DF, IP_FRAG_LO}
				+ {IP_TTL, proto} + own_ip[31:16] + own_ip[15:0] + dip[31:16] + dip[15:0];
			while (sum > 32'h0000_FFFF) begin
				sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
			end
			return sum[15:0];
		endfunction

		function void note_request(logic [47:0] dmac, logic [31:0] dip, logic [7:0] proto,
				logic [15:0] plen);
			logic [7:0]  hdr [HDR_BYTES];
			logic [15:0] total;
			logic [15:0] csum;
			hdr_word_t   w;
			total = plen + IP_LEN_BIAS;
			csum  = ~ones_sum(dip, proto, plen);
			for (int i = 0; i < 6; i++) begin
				hdr[i]     = dmac[47 - 8 * i -: 8];
				hdr[6 + i] = own_mac[47 - 8 * i -: 8];
			end
			hdr[12] = ETH_TYPE_HI;
			hdr[13] = ETH_TYPE_LO;
			hdr[14] = IP_VER_IHL;
			hdr[15] = IP_TOS;
			hdr[16] = total[15:8];
			hdr[17] = total[7:0];
			hdr[18] = ident[15:8];
			hdr[19] = ident[7:0];
			hdr[20] = IP_FLAGS_DF;
			hdr[21] = IP_FRAG_LO;
			hdr[22] = IP_TTL;
			hdr[23] = proto;
			hdr[24] = csum[15:8];
			hdr[25] = csum[7:0];
			for (int i = 0; i < 4; i++) begin
				hdr[26 + i] = own_ip[31 - 8 * i -: 8];
				hdr[30 + i] = dip[31 - 8 * i -: 8];
			end
			for (int i = 0; i < HDR_BYTES; i++) begin
				w.hbyte = hdr[i];
				w.idx   = 6'(i);
				w.lst   = (i == HDR_BYTES - 1);
				hdr_words.push_back(w);
			end
			ident = ident + 16'd1;
		endfunction

		function void check_word(logic [7:0] hbyte, logic [5:0] idx, logic lst);
			hdr_word_t w;
			if (hdr_words.size() == 0) begin
				$display("%0t: unexpected word: header_byte %h byte_index %0d last %b",
					$time, hbyte, idx, lst);
				errors++;
				return;
			end
			w = hdr_words.pop_front();
			if (hbyte !== w.hbyte) begin
				$display("%0t: header_byte at index %0d: expected %h, actual %h",
					$time, w.idx, w.hbyte, hbyte);
				errors++;
			end
			if (idx !== w.idx) begin
				$display("%0t: byte_index: expected %0d, actual %0d", $time, w.idx, idx);
				errors++;
			end
			if (lst !== w.lst) begin
				$display("%0t: last at index %0d: expected %b, actual %b",
					$time, w.idx, w.lst, lst);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_index;
	logic [47:0] cfg_wdata;
	logic        push;
	logic        full;
	logic [47:0] dest_mac_addr;
	logic [31:0] dest_ip_addr;
	logic [7:0]  protocol;
	logic [15:0] payload_length;
	logic        pop = 1'b0;
	logic        empty;
	logic [7:0]  header_byte;
	logic [5:0]  byte_index;
	logic        last;

	hdr_scoreboard sb = new();
	bit            calm = 1'b0;
	int unsigned   cycle_count = 0;

	ipv4_eth_header_builder_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.push           (push),
		.full           (full),
		.dest_mac_addr  (dest_mac_addr),
		.dest_ip_addr   (dest_ip_addr),
		.protocol       (protocol),
		.payload_length (payload_length),
		.pop            (pop),
		.empty          (empty),
		.header_byte    (header_byte),
		.byte_index     (byte_index),
		.last           (last)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		pop <= calm || ($urandom_range(0, 99) >= 32);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			sb.check_word(header_byte, byte_index, last);
		end
	end

	task automatic send_request(logic [47:0] dmac, logic [31:0] dip, logic [7:0] proto,
			logic [15:0] plen);
		while (!calm && $urandom_range(0, 99) < 32) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push           <= 1'b1;
		dest_mac_addr  <= dmac;
		dest_ip_addr   <= dip;
		protocol       <= proto;
		payload_length <= plen;
		do @(posedge clk); while (full);
		sb.note_request(dmac, dip, proto, plen);
	endtask

	// picks the low dip half so the ip header sums to all ones
	task automatic send_all_ones_sum(logic [47:0] dmac, logic [15:0] dip_hi, logic [7:0] proto,
			logic [15:0] plen);
		logic [15:0] s;
		s = sb.ones_sum({dip_hi, 16'h0000}, proto, plen);
		send_request(dmac, {dip_hi, 16'hFFFF - s}, proto, plen);
	endtask

	task automatic send_random(int n);
		logic [47:0] dmac;
		logic [31:0] dip;
		logic [7:0]  proto;
		logic [15:0] plen;
		for (int k = 0; k < n; k++) begin
			dmac = {16'($urandom), 32'($urandom)};
			dip  = $urandom;
			case ($urandom_range(0, 9))
				0: proto = 8'd6;
				1: proto = 8'd17;
				default: proto = 8'($urandom);
			endcase
			if ($urandom_range(0, 7) == 0) begin
				plen = 16'($urandom);
			end else begin
				plen = 16'($urandom_range(0, 65515));
			end
			send_request(dmac, dip, proto, plen);
		end
	endtask

	task automatic write_regs(logic [47:0] mac, logic [47:0] ip_word, logic [7:0] stray_idx);
		logic [47:0] stray_data;
		stray_data = {16'($urandom), 32'($urandom)};
		cfg_we    <= 1'b1;
		cfg_index <= CFG_OWN_MAC;
		cfg_wdata <= mac;
		sb.write_reg(CFG_OWN_MAC, mac);
		@(posedge clk);
		cfg_index <= CFG_OWN_IP;
		cfg_wdata <= ip_word;
		sb.write_reg(CFG_OWN_IP, ip_word);
		@(posedge clk);
		cfg_index <= stray_idx;
		cfg_wdata <= stray_data;
		sb.write_reg(stray_idx, stray_data);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (sb.hdr_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= '0;
		cfg_wdata      <= '0;
		push           <= 1'b0;
		dest_mac_addr  <= '0;
		dest_ip_addr   <= '0;
		protocol       <= '0;
		payload_length <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: field extremes, length wrap, all-ones checksum sum
		write_regs(48'h0, 48'h0, CFG_UNUSED_LO);
		send_request(48'h0, 32'h0, 8'd0, 16'd0);
		send_request(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'd65515);
		send_request(48'h0102_0304_0506, 32'hC0A8_0001, 8'd6, 16'd65516);
		send_request(48'hFFFF_FFFF_FFFF, 32'h0A00_0001, 8'd17, 16'hFFFF);
		send_request(48'hAAAA_AAAA_AAAA, 32'h5555_5555, 8'd1, 16'd1460);
		send_request(48'h5555_5555_5555, 32'hAAAA_AAAA, 8'hAA, 16'h5555);
		send_request(48'h0, 32'hFFFF_FFFF, 8'h55, 16'hAAAA);
		send_all_ones_sum(48'h0011_2233_4455, 16'hC0A8, 8'd17, 16'd8);
		send_all_ones_sum(48'hFFFF_FFFF_FFFF, 16'h0000, 8'd0, 16'd0);
		wait_drained();

		write_regs(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, CFG_UNUSED_HI);
		send_request(48'h0, 32'h0, 8'd0, 16'd0);
		send_request(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'd65515);
		send_request(48'h1234_5678_9ABC, 32'h7F00_0001, 8'd6, 16'd65530);
		send_all_ones_sum(48'h0A0B_0C0D_0E0F, 16'h0A01, 8'd6, 16'd40);
		send_random(35);
		wait_drained();

		// both sides without idling
		calm = 1'b1;
		write_regs({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
			8'($urandom_range(2, 255)));
		send_random(40);
		wait_drained();
		calm = 1'b0;

		write_regs({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
			8'($urandom_range(2, 255)));
		send_random(40);
		wait_drained();

		write_regs(48'h0, 48'hFFFF_FFFF_FFFF, 8'($urandom_range(2, 255)));
		send_random(35);
		wait_drained();

		if (sb.errors == 0 && sb.hdr_words.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ihb_pkg.sv
hdl/ihb_front.sv
hdl/ihb_fifo.sv
hdl/ihb_back.sv
hdl/ipv4_eth_header_builder_unit.sv
test/tb_ipv4_eth_header_builder_unit.sv
